@@ sv/hds_pkg.sv @@
// shared types, constants and helpers for the heat diffusion stencil
package hds_pkg;

    localparam int HEAT_BITS      = 16;
    localparam int SUM_BITS       = HEAT_BITS + 3;
    localparam int DECAY_BITS     = 16;
    localparam int CFG_DIM_BITS   = 11;
    localparam int APB_DATA_BITS  = 32;
    localparam int PADDR_BITS     = 4;
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam logic [CFG_DIM_BITS-1:0] RST_FRAME_WIDTH  = CFG_DIM_BITS'(640);
    localparam logic [CFG_DIM_BITS-1:0] RST_FRAME_HEIGHT = CFG_DIM_BITS'(480);
    localparam logic [DECAY_BITS-1:0]   RST_DECAY        = DECAY_BITS'(65470);

    typedef enum logic [1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_DECAY        = 2'd2
    } t_reg_idx;

    typedef logic signed [HEAT_BITS-1:0] t_heat;
    typedef logic signed [SUM_BITS-1:0]  t_sum_val;

    // one column of the window, index 0 is the oldest row
    typedef t_heat [2:0] t_col;

    typedef struct packed {
        t_heat heat_in;
        logic  is_pad;
    } t_in;

    typedef struct packed {
        t_heat heat_out;
        logic  frame_done;
    } t_out;

    typedef struct packed {
        t_sum_val sum;
        logic     last;
    } t_sum;

    function automatic t_sum_val col_sum(input t_col col, input logic [2:0] keep);
        t_sum_val acc;
        acc = '0;
        for (int k = 0; k < 3; k++) begin
            if (keep[k]) begin
                acc = acc + SUM_BITS'(signed'(col[k]));
            end
        end
        return acc;
    endfunction

endpackage

@@ sv/hds_column_cell.sv @@
// one window column cell: holds a column, passes it on, gives its masked sum
module hds_column_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_shift,
    input  hds_pkg::t_col i_col,
    input  logic [2:0]    i_keep,
    output hds_pkg::t_col o_col,
    output hds_pkg::t_sum_val o_part
);
    import hds_pkg::*;

    t_col r_col;
    t_col n_col;

    always_comb begin
        n_col = i_shift ? i_col : r_col;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else begin
            r_col <= n_col;
        end
    end

    assign o_col  = r_col;
    assign o_part = col_sum(r_col, i_keep);

endmodule

@@ sv/hds_line_buffer.sv @@
// line buffer holding the two previous rows, one read and one write a cycle
module hds_line_buffer #(
    parameter int DEPTH = hds_pkg::DEF_MAX_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]      i_rd_addr,
    output logic [2*hds_pkg::HEAT_BITS-1:0] o_rd_data,
    input  logic                          i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]      i_wr_addr,
    input  logic [2*hds_pkg::HEAT_BITS-1:0] i_wr_data
);
    import hds_pkg::*;

    logic [2*HEAT_BITS-1:0] r_mem [DEPTH];
    logic [2*HEAT_BITS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ sv/hds_scale.sv @@
// decay multiply, floor shift and saturation, with output register
module hds_scale (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  hds_pkg::t_sum                   i_sum,
    input  logic [hds_pkg::DECAY_BITS-1:0]  i_decay,
    output logic                            o_valid,
    input  logic                            i_stall,
    output hds_pkg::t_out                   o_data
);
    import hds_pkg::*;

    localparam int PROD_BITS = SUM_BITS + DECAY_BITS + 1;
    localparam int SHIFT     = DECAY_BITS + 3;
    localparam int Q_BITS    = PROD_BITS - SHIFT;

    logic                        r_a_vld;
    t_sum                        r_a;
    logic                        r_b_vld;
    logic signed [PROD_BITS-1:0] r_prod;
    logic                        r_b_last;
    logic                        r_out_vld;
    t_out                        r_out;

    logic                        out_ready;
    logic                        b_ready;
    logic                        a_ready;
    logic signed [PROD_BITS-1:0] n_prod;
    logic signed [Q_BITS-1:0]    q;
    logic                        q_fits;
    t_heat                       n_heat;

    assign out_ready = !r_out_vld || !i_stall;
    assign b_ready   = !r_b_vld || out_ready;
    assign a_ready   = !r_a_vld || b_ready;
    assign o_stall   = !a_ready;

    always_comb begin
        n_prod = PROD_BITS'(r_a.sum) * PROD_BITS'($signed({1'b0, i_decay}));
    end

    // arithmetic shift gives the floor
    always_comb begin
        q      = r_prod[PROD_BITS-1:SHIFT];
        q_fits = (q[Q_BITS-1:HEAT_BITS-1] == '0) || (q[Q_BITS-1:HEAT_BITS-1] == '1);
        if (q_fits) begin
            n_heat = q[HEAT_BITS-1:0];
        end else if (q[Q_BITS-1]) begin
            n_heat = {1'b1, {(HEAT_BITS-1){1'b0}}};
        end else begin
            n_heat = {1'b0, {(HEAT_BITS-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld   <= 1'b0;
            r_b_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (a_ready) begin
                r_a_vld <= i_valid;
            end
            if (b_ready) begin
                r_b_vld <= r_a_vld;
            end
            if (out_ready) begin
                r_out_vld <= r_b_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_ready && i_valid) begin
            r_a <= i_sum;
        end
        if (b_ready && r_a_vld) begin
            r_prod   <= n_prod;
            r_b_last <= r_a.last;
        end
        if (out_ready && r_b_vld) begin
            r_out.heat_out   <= n_heat;
            r_out.frame_done <= r_b_last;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

endmodule

@@ sv/heat_diffusion_stencil_core.sv @@
// top level of the heat diffusion stencil: position tracking, window and config port
//
// Takes one grid cell per clock in raster order and returns, per cell, the sum of its
// eight neighbours times decay / 8 (signed Q8.8, floored, saturated); cells outside the
// grid count as zero. The result for a cell comes out frame_width + 1 requests after the
// cell went in, so frame_width + 1 pad requests must follow each frame to flush it; the
// last result of a frame carries frame_done. Sustained rate is one request per cycle when
// i_stall holds nothing back, set by the single-port-pair line buffer (one read and one
// write a cycle) and the two-cell window chain. An accepted request goes in order through
// line buffer read with neighbour sum, decay multiply and saturate to o_valid. Registers:
// frame_width at 0x0, frame_height at 0x4, decay at 0x8; write them only while idle.
module heat_diffusion_stencil_core #(
    parameter int MAX_WIDTH  = hds_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = hds_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  hds_pkg::t_in                        i_data,
    output logic                                o_valid,
    input  logic                                i_stall,
    output hds_pkg::t_out                       o_data,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [hds_pkg::PADDR_BITS-1:0]      paddr,
    input  logic [hds_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [hds_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                pready
);
    import hds_pkg::*;

    localparam int CBITS = $clog2(MAX_WIDTH);
    localparam int WBITS = $clog2(MAX_WIDTH + 1);
    localparam int HBITS = $clog2(MAX_HEIGHT + 1);
    localparam int RBITS = $clog2(MAX_HEIGHT + 3);

    typedef struct packed {
        logic top;
        logic bot;
        logic left;
        logic right;
    } t_mask;

    // configuration
    logic [CFG_DIM_BITS-1:0] r_frame_width;
    logic [CFG_DIM_BITS-1:0] r_frame_height;
    logic [DECAY_BITS-1:0]   r_decay;
    logic                    cfg_we;

    // stream position
    logic [CBITS-1:0] r_col;
    logic [RBITS-1:0] r_row;
    logic [CBITS-1:0] n_col;
    logic [RBITS-1:0] n_row;

    // first stage
    logic             r_s1_vld;
    t_heat            r_s1_heat;
    logic [CBITS-1:0] r_s1_col;
    logic             r_s1_emit;
    logic             r_s1_last;
    t_mask            r_s1_mask;

    logic [WBITS-1:0] w;
    logic [HBITS-1:0] h;
    logic [RBITS-1:0] h_ext;
    logic             col_wrap;
    logic [CBITS-1:0] cur_col;
    logic [RBITS-1:0] cur_row;
    logic             cur_last;
    logic             cur_emit;
    logic             col_is0;
    logic             col_is1;
    t_mask            cur_mask;
    logic [WBITS-1:0] col_inc;
    t_heat            cur_heat;

    logic             accept;
    logic             s1_ready;
    logic             s1_adv;
    logic             win_shift;
    logic             sc_stall;

    logic [2*HEAT_BITS-1:0] rd_data;
    t_col             fresh;
    t_col             new_col;
    t_col             old_col;
    logic [2:0]       row_keep;
    t_sum_val         part_new;
    t_sum_val         part_old;
    t_sum             s1_sum;

    // register port
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
            r_decay        <= RST_DECAY;
        end else if (cfg_we) begin
            unique case (paddr[PADDR_BITS-1:2])
                REG_FRAME_WIDTH:  r_frame_width  <= pwdata[CFG_DIM_BITS-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= pwdata[CFG_DIM_BITS-1:0];
                REG_DECAY:        r_decay        <= pwdata[DECAY_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[PADDR_BITS-1:2])
            REG_FRAME_WIDTH:  prdata = APB_DATA_BITS'(r_frame_width);
            REG_FRAME_HEIGHT: prdata = APB_DATA_BITS'(r_frame_height);
            REG_DECAY:        prdata = APB_DATA_BITS'(r_decay);
            default:          prdata = '0;
        endcase
    end

    // dimensions in use
    always_comb begin
        if (r_frame_width < CFG_DIM_BITS'(3)) begin
            w = WBITS'(3);
        end else if (32'(r_frame_width) > MAX_WIDTH) begin
            w = WBITS'(MAX_WIDTH);
        end else begin
            w = WBITS'(r_frame_width);
        end
        if (r_frame_height < CFG_DIM_BITS'(3)) begin
            h = HBITS'(3);
        end else if (32'(r_frame_height) > MAX_HEIGHT) begin
            h = HBITS'(MAX_HEIGHT);
        end else begin
            h = HBITS'(r_frame_height);
        end
        h_ext = RBITS'(h);
    end

    // position of the incoming request and which cell it completes
    always_comb begin
        col_wrap = WBITS'(r_col) >= w;
        cur_col  = col_wrap ? '0 : r_col;
        cur_row  = col_wrap ? r_row + RBITS'(1) : r_row;
        cur_last = cur_row >= h_ext + RBITS'(1);
        col_is0  = cur_col == '0;
        col_is1  = cur_col == CBITS'(1);
        cur_emit = cur_last || (!col_is0 && cur_row != '0)
                   || (col_is0 && cur_row >= RBITS'(2));
        // flags set where the emitted cell has a neighbour above, below, to the left or to the right
        cur_mask.top   = cur_last || (col_is0 ? cur_row != RBITS'(2) : cur_row != RBITS'(1));
        cur_mask.bot   = !cur_last && (col_is0 || cur_row != h_ext);
        cur_mask.left  = cur_last || !col_is1;
        // at column zero the emitted cell is the last one of the row two above the incoming request
        cur_mask.right = !cur_last && !col_is0;
        cur_heat = i_data.is_pad ? '0 : i_data.heat_in;

        col_inc = WBITS'(cur_col) + WBITS'(1);
        if (cur_last) begin
            n_col = '0;
            n_row = '0;
        end else if (col_inc >= w) begin
            n_col = '0;
            n_row = cur_row + RBITS'(1);
        end else begin
            n_col = col_inc[CBITS-1:0];
            n_row = cur_row;
        end
    end

    // handshake through the first stage
    assign s1_adv   = r_s1_vld && (!r_s1_emit || !sc_stall);
    assign s1_ready = !r_s1_vld || s1_adv;
    assign accept   = i_valid && s1_ready;
    assign o_stall  = !s1_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_s1_vld <= 1'b0;
        end else begin
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (s1_ready) begin
                r_s1_vld <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_heat <= cur_heat;
            r_s1_col  <= cur_col;
            r_s1_emit <= cur_emit;
            r_s1_last <= cur_last;
            r_s1_mask <= cur_mask;
        end
    end

    // upper half holds the previous row, lower half the one before it
    hds_line_buffer #(
        .DEPTH (MAX_WIDTH)
    ) u_line_buffer (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (cur_col),
        .o_rd_data (rd_data),
        .i_wr_en   (win_shift),
        .i_wr_addr (r_s1_col),
        .i_wr_data ({r_s1_heat, rd_data[2*HEAT_BITS-1:HEAT_BITS]})
    );

    assign fresh     = {r_s1_heat, rd_data[2*HEAT_BITS-1:HEAT_BITS], rd_data[HEAT_BITS-1:0]};
    assign win_shift = s1_adv && !r_s1_last;
    assign row_keep  = {r_s1_mask.bot, 1'b1, r_s1_mask.top};

    // newer column, center cell left out
    hds_column_cell u_cell_new (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (win_shift),
        .i_col   (fresh),
        .i_keep  ({r_s1_mask.bot, 1'b0, r_s1_mask.top}),
        .o_col   (new_col),
        .o_part  (part_new)
    );

    hds_column_cell u_cell_old (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (win_shift),
        .i_col   (new_col),
        .i_keep  (row_keep & {3{r_s1_mask.left}}),
        .o_col   (old_col),
        .o_part  (part_old)
    );

    always_comb begin
        s1_sum.sum  = part_old + part_new + col_sum(fresh, row_keep & {3{r_s1_mask.right}});
        s1_sum.last = r_s1_last;
    end

    hds_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s1_vld && r_s1_emit),
        .o_stall (sc_stall),
        .i_sum   (s1_sum),
        .i_decay (r_decay),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

endmodule
